[design/osur_pkg.sv]
`default_nettype none

package osur_pkg;

  localparam int RING_DEPTH    = 16;
  localparam int TICKS_PER_BIT = 4;
  localparam int LAST_DATA_BIT = 9;

  localparam int PTR_W  = $clog2(RING_DEPTH);
  localparam int TICK_W = $clog2(TICKS_PER_BIT);
  localparam int BIT_W  = 4;
  localparam int BYTE_W = 8;

  localparam int IN_TDATA_W  = 16;
  localparam int IN_TUSER_W  = 2;
  localparam int OUT_TDATA_W = 16;

  localparam int IN_LINE_POS  = 0;
  localparam int IN_BYTE_LSB  = 1;

  localparam int OUT_TX_LINE_POS  = 0;
  localparam int OUT_TX_BUSY_POS  = 1;
  localparam int OUT_RX_BUSY_POS  = 2;
  localparam int OUT_READY_POS    = 3;
  localparam int OUT_ACCEPTED_POS = 4;
  localparam int OUT_BYTE_LSB     = 5;
  localparam int OUT_VALID_POS    = 13;

  typedef enum logic [1:0] {
    ACT_TICK = 2'd0,
    ACT_SEND = 2'd1,
    ACT_READ = 2'd2
  } action_t;

  typedef struct packed {
    logic tick;
    logic send;
    logic read;
  } step_t;

endpackage

`default_nettype wire

[design/osur_tx.sv]
`default_nettype none

module osur_tx (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire osur_pkg::step_t             step,
  input  wire logic [osur_pkg::BYTE_W-1:0] send_byte,
  output logic                             tx_level,
  output logic                             tx_busy,
  output logic                             send_accepted
);

  logic [osur_pkg::BYTE_W-1:0] shift_r, shift_nxt;
  logic [osur_pkg::TICK_W-1:0] tick_r, tick_nxt;
  logic [osur_pkg::BIT_W-1:0]  bit_r, bit_nxt;
  logic                        active_r, active_nxt;
  logic                        level_r, level_nxt;

  always_comb begin
    shift_nxt     = shift_r;
    tick_nxt      = tick_r;
    bit_nxt       = bit_r;
    active_nxt    = active_r;
    level_nxt     = level_r;
    send_accepted = 1'b0;
    if (step.send && !active_r) begin
      shift_nxt     = send_byte;
      active_nxt    = 1'b1;
      send_accepted = 1'b1;
    end else if (step.tick && active_r) begin
      if (tick_r == osur_pkg::TICK_W'(osur_pkg::TICKS_PER_BIT - 1)) begin
        tick_nxt = '0;
        if (bit_r == '0) begin
          level_nxt = 1'b0;
        end else if (bit_r != osur_pkg::BIT_W'(osur_pkg::LAST_DATA_BIT)) begin
          level_nxt = shift_r[0];
          shift_nxt = shift_r >> 1;
        end else begin
          level_nxt = 1'b1;
        end
        if (bit_r == osur_pkg::BIT_W'(osur_pkg::LAST_DATA_BIT)) begin
          bit_nxt    = '0;
          active_nxt = 1'b0;
        end else begin
          bit_nxt = bit_r + osur_pkg::BIT_W'(1);
        end
      end else begin
        tick_nxt = tick_r + osur_pkg::TICK_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      shift_r  <= '0;
      tick_r   <= '0;
      bit_r    <= '0;
      active_r <= 1'b0;
      level_r  <= 1'b1;
    end else begin
      shift_r  <= shift_nxt;
      tick_r   <= tick_nxt;
      bit_r    <= bit_nxt;
      active_r <= active_nxt;
      level_r  <= level_nxt;
    end
  end

  assign tx_level = level_nxt;
  assign tx_busy  = active_nxt;

endmodule

`default_nettype wire

[design/osur_rx.sv]
`default_nettype none

module osur_rx (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire osur_pkg::step_t             step,
  input  wire logic                        rx_line,
  output logic                             rx_busy,
  output logic                             push,
  output logic [osur_pkg::BYTE_W-1:0]      push_data
);

  logic [osur_pkg::BYTE_W-1:0] asm_r, asm_nxt;
  logic [osur_pkg::TICK_W-1:0] tick_r, tick_nxt;
  logic [osur_pkg::BIT_W-1:0]  bit_r, bit_nxt;
  logic [osur_pkg::BIT_W-1:0]  bit_m1;
  logic                        active_r, active_nxt;

  assign bit_m1 = bit_r - osur_pkg::BIT_W'(1);

  always_comb begin
    asm_nxt    = asm_r;
    tick_nxt   = tick_r;
    bit_nxt    = bit_r;
    active_nxt = active_r;
    push       = 1'b0;
    if (step.tick) begin
      if (!active_r) begin
        if (!rx_line) begin
          tick_nxt   = osur_pkg::TICK_W'(osur_pkg::TICKS_PER_BIT / 2);
          active_nxt = 1'b1;
          bit_nxt    = '0;
        end
      end else if (tick_r == osur_pkg::TICK_W'(osur_pkg::TICKS_PER_BIT - 1)) begin
        tick_nxt = '0;
        if (bit_r == '0) begin
          if (!rx_line) begin
            bit_nxt = osur_pkg::BIT_W'(1);
            asm_nxt = '0;
          end else begin
            active_nxt = 1'b0;
          end
        end else if (bit_r < osur_pkg::BIT_W'(osur_pkg::LAST_DATA_BIT)) begin
          if (rx_line) begin
            asm_nxt[bit_m1[$clog2(osur_pkg::BYTE_W)-1:0]] = 1'b1;
          end
          bit_nxt = bit_r + osur_pkg::BIT_W'(1);
        end else if (bit_r == osur_pkg::BIT_W'(osur_pkg::LAST_DATA_BIT)) begin
          bit_nxt = bit_r + osur_pkg::BIT_W'(1);
        end else begin
          active_nxt = 1'b0;
          push       = 1'b1;
        end
      end else begin
        tick_nxt = tick_r + osur_pkg::TICK_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      asm_r    <= '0;
      tick_r   <= '0;
      bit_r    <= '0;
      active_r <= 1'b0;
    end else begin
      asm_r    <= asm_nxt;
      tick_r   <= tick_nxt;
      bit_r    <= bit_nxt;
      active_r <= active_nxt;
    end
  end

  assign rx_busy   = active_nxt;
  assign push_data = asm_r;

endmodule

`default_nettype wire

[design/osur_ring.sv]
`default_nettype none

module osur_ring (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire osur_pkg::step_t             step,
  input  wire logic                        push,
  input  wire logic [osur_pkg::BYTE_W-1:0] push_data,
  output logic                             pop_valid,
  output logic                             data_ready,
  output logic [osur_pkg::BYTE_W-1:0]      rdata_r
);

  logic [osur_pkg::BYTE_W-1:0] mem [osur_pkg::RING_DEPTH];
  logic [osur_pkg::PTR_W-1:0]  head_r, head_nxt;
  logic [osur_pkg::PTR_W-1:0]  tail_r, tail_nxt;

  function automatic logic [osur_pkg::PTR_W-1:0] ptr_inc(input logic [osur_pkg::PTR_W-1:0] p);
    ptr_inc = (p == osur_pkg::PTR_W'(osur_pkg::RING_DEPTH - 1)) ? '0
                                                              : p + osur_pkg::PTR_W'(1);
  endfunction

  assign pop_valid = step.read && (head_r != tail_r);

  always_comb begin
    head_nxt = head_r;
    tail_nxt = tail_r;
    if (push) begin
      head_nxt = ptr_inc(head_r);
    end
    if (pop_valid) begin
      tail_nxt = ptr_inc(tail_r);
    end
  end

  assign data_ready = (head_nxt != tail_nxt);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r <= '0;
      tail_r <= '0;
    end else begin
      head_r <= head_nxt;
      tail_r <= tail_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[head_r] <= push_data;
    end
    if (pop_valid) begin
      rdata_r <= mem[tail_r];
    end
  end

endmodule

`default_nettype wire

[design/oversampled_uart_with_rx_ring.sv]
// Channel | Direction | tdata (lowest bit up)                           | tuser
// in_     | slave     | rx_line, send_byte, zero pad to 16              | action
// out_    | master    | tx_line, tx_busy, rx_busy, data_ready,          | none
//         |           | send_accepted, read_byte, read_valid, zero pad  |
// One word is accepted per clock unless the output stalls; each word is taken into
// an input register and processed when the output register is free to take its result.
// A stalled output holds its word, and the input register and ready back up behind it.
// Synchronous active-low reset idles both serial engines and empties the receive ring.
`default_nettype none

module oversampled_uart_with_rx_ring (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             in_tvalid,
  output logic                                  in_tready,
  // rx_line, send_byte, zero pad
  input  wire logic [osur_pkg::IN_TDATA_W-1:0]  in_tdata,
  // action
  input  wire logic [osur_pkg::IN_TUSER_W-1:0]  in_tuser,
  output logic                                  out_tvalid,
  input  wire logic                             out_tready,
  // tx_line, tx_busy, rx_busy, data_ready, send_accepted, read_byte, read_valid, zero pad
  output logic [osur_pkg::OUT_TDATA_W-1:0]      out_tdata
);

  logic                        s1_valid_r;
  osur_pkg::action_t           s1_action_r;
  logic                        s1_line_r;
  logic [osur_pkg::BYTE_W-1:0] s1_byte_r;
  logic                        advance;
  osur_pkg::step_t             step;

  logic                        tx_level, tx_busy, send_accepted;
  logic                        rx_busy, push;
  logic [osur_pkg::BYTE_W-1:0] push_data;
  logic                        pop_valid, data_ready;
  logic [osur_pkg::BYTE_W-1:0] rdata_r;

  logic                        out_valid_r;
  logic                        tx_line_r, tx_busy_r, rx_busy_r, ready_r;
  logic                        accepted_r, read_valid_r;

  assign advance   = s1_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !s1_valid_r || advance;

  always_comb begin
    step = '0;
    if (advance) begin
      unique case (s1_action_r)
        osur_pkg::ACT_TICK: step.tick = 1'b1;
        osur_pkg::ACT_SEND: step.send = 1'b1;
        osur_pkg::ACT_READ: step.read = 1'b1;
        default:            step      = '0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tready) begin
      s1_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      s1_action_r <= osur_pkg::action_t'(in_tuser);
      s1_line_r   <= in_tdata[osur_pkg::IN_LINE_POS];
      s1_byte_r   <= in_tdata[osur_pkg::IN_BYTE_LSB +: osur_pkg::BYTE_W];
    end
  end

  osur_tx u_tx (
    .clk           (clk),
    .rst_n         (rst_n),
    .step          (step),
    .send_byte     (s1_byte_r),
    .tx_level      (tx_level),
    .tx_busy       (tx_busy),
    .send_accepted (send_accepted)
  );

  osur_rx u_rx (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (step),
    .rx_line   (s1_line_r),
    .rx_busy   (rx_busy),
    .push      (push),
    .push_data (push_data)
  );

  osur_ring u_ring (
    .clk        (clk),
    .rst_n      (rst_n),
    .step       (step),
    .push       (push),
    .push_data  (push_data),
    .pop_valid  (pop_valid),
    .data_ready (data_ready),
    .rdata_r    (rdata_r)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      tx_line_r    <= tx_level;
      tx_busy_r    <= tx_busy;
      rx_busy_r    <= rx_busy;
      ready_r      <= data_ready;
      accepted_r   <= send_accepted;
      read_valid_r <= pop_valid;
    end
  end

  assign out_tvalid = out_valid_r;

  always_comb begin
    out_tdata                                   = '0;
    out_tdata[osur_pkg::OUT_TX_LINE_POS]        = tx_line_r;
    out_tdata[osur_pkg::OUT_TX_BUSY_POS]        = tx_busy_r;
    out_tdata[osur_pkg::OUT_RX_BUSY_POS]        = rx_busy_r;
    out_tdata[osur_pkg::OUT_READY_POS]          = ready_r;
    out_tdata[osur_pkg::OUT_ACCEPTED_POS]       = accepted_r;
    out_tdata[osur_pkg::OUT_BYTE_LSB +: osur_pkg::BYTE_W] =
      read_valid_r ? rdata_r : '0;
    out_tdata[osur_pkg::OUT_VALID_POS]          = read_valid_r;
  end

endmodule

`default_nettype wire

[design/osur_checker.sv]
`default_nettype none

module osur_checker (
  input wire logic                             clk,
  input wire logic                             rst_n,
  input wire logic                             in_tvalid,
  input wire logic                             in_tready,
  input wire logic [osur_pkg::IN_TDATA_W-1:0]  in_tdata,
  input wire logic [osur_pkg::IN_TUSER_W-1:0]  in_tuser,
  input wire logic                             out_tvalid,
  input wire logic                             out_tready,
  input wire logic [osur_pkg::OUT_TDATA_W-1:0] out_tdata
);

  logic in_seen;
  assign in_seen = in_tvalid && in_tready && (in_tdata == in_tdata) && (in_tuser == in_tuser);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result word changed while stalled");

  a_byte_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tdata[osur_pkg::OUT_VALID_POS] |->
      out_tdata[osur_pkg::OUT_BYTE_LSB +: osur_pkg::BYTE_W] == '0)
    else $error("read byte nonzero without a valid read");

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[osur_pkg::OUT_ACCEPTED_POS] |->
      out_tdata[osur_pkg::OUT_TX_BUSY_POS] && !out_tdata[osur_pkg::OUT_VALID_POS])
    else $error("accepted send without busy transmitter");

  a_idle_high: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tdata[osur_pkg::OUT_TX_BUSY_POS] |->
      out_tdata[osur_pkg::OUT_TX_LINE_POS])
    else $error("transmit line low while transmitter idle");

  a_first_out: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> $past(in_seen, 2) || $past(out_tvalid))
    else $error("result word without an accepted input word");

endmodule

bind oversampled_uart_with_rx_ring osur_checker u_osur_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tdata   (in_tdata),
  .in_tuser   (in_tuser),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

`default_nettype wire
